// ===== rtl/lort_pkg.sv =====
`timescale 1ns / 1ps

package lort_pkg;

  localparam int POS_W = 10;
  localparam int LEN_W = 11;
  localparam int CFG_W = 11;

  localparam logic [CFG_W-1:0] N_BITS_RESET = 11'd1024;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] position;
    logic             bit_value;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] longest_run;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] n_bits;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_EXEC,
    ST_LD_EXEC,
    ST_WR_A,
    ST_WR_B,
    ST_QUERY
  } state_t;

  typedef struct packed {
    logic take;
    logic clear;
    logic set_rd;
    logic set_exec;
    logic ld_exec;
    logic wr_a;
    logic wr_b;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic item_valid;
    logic go_load;
    logic go_set;
    logic go_query;
    logic bm_one;
    logic ld_more;
    logic need_b;
    logic out_free;
    logic clr_last;
  } stat_t;

endpackage

// ===== rtl/lort_chan_if.sv =====
`timescale 1ns / 1ps

interface lort_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lort_ctrl.sv =====
`timescale 1ns / 1ps

module lort_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  lort_pkg::stat_t stat,
  output lort_pkg::cmd_t  cmd
);

  lort_pkg::state_t state;
  lort_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lort_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      lort_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = lort_pkg::ST_IDLE;
        end
      end
      lort_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (stat.item_valid) begin
          if (stat.go_query) begin
            state_next = lort_pkg::ST_QUERY;
          end else if (stat.go_load) begin
            state_next = lort_pkg::ST_LD_EXEC;
          end else if (stat.go_set) begin
            state_next = lort_pkg::ST_SET_RD;
          end
        end
      end
      lort_pkg::ST_SET_RD: begin
        cmd.set_rd = 1'b1;
        state_next = lort_pkg::ST_SET_EXEC;
      end
      lort_pkg::ST_SET_EXEC: begin
        cmd.set_exec = 1'b1;
        state_next   = stat.bm_one ? lort_pkg::ST_IDLE : lort_pkg::ST_WR_A;
      end
      lort_pkg::ST_LD_EXEC: begin
        cmd.ld_exec = 1'b1;
        state_next  = stat.ld_more ? lort_pkg::ST_WR_A : lort_pkg::ST_IDLE;
      end
      lort_pkg::ST_WR_A: begin
        cmd.wr_a   = 1'b1;
        state_next = stat.need_b ? lort_pkg::ST_WR_B : lort_pkg::ST_IDLE;
      end
      lort_pkg::ST_WR_B: begin
        cmd.wr_b   = 1'b1;
        state_next = lort_pkg::ST_IDLE;
      end
      lort_pkg::ST_QUERY: begin
        cmd.load_out = stat.out_free;
        if (stat.out_free) begin
          state_next = lort_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lort_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/lort_dpath.sv =====
`timescale 1ns / 1ps

module lort_dpath #(
  parameter int MAX_BITS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  lort_chan_if.sink       item,
  lort_chan_if.source     result,
  lort_chan_if.sink       cfg,
  input  lort_pkg::cmd_t  cmd,
  output lort_pkg::stat_t stat
);

  localparam int AW    = $clog2(MAX_BITS);
  localparam int SZ_R  = $clog2(MAX_BITS + 1);
  localparam int SZ_W  = (SZ_R > lort_pkg::LEN_W) ? SZ_R : lort_pkg::LEN_W;
  localparam int POS_W = lort_pkg::POS_W;
  localparam int LEN_W = lort_pkg::LEN_W;
  localparam logic [SZ_W-1:0]  MAX_SZ  = SZ_W'(MAX_BITS);
  localparam logic [AW-1:0]    CLR_END = AW'(MAX_BITS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  function automatic logic fits(input logic [POS_W-1:0] v);
    fits = SZ_W'(v) < MAX_SZ;
  endfunction

  function automatic logic [LEN_W-1:0] len_max(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    len_max = (a > b) ? a : b;
  endfunction

  logic              bm_mem [MAX_BITS];
  logic [POS_W-1:0]  rs_mem [MAX_BITS];
  logic [POS_W-1:0]  re_mem [MAX_BITS];

  logic [lort_pkg::CFG_W-1:0] n_bits;
  logic [POS_W-1:0]  pos;
  logic              bitv;
  logic [AW-1:0]     clr;
  logic [LEN_W-1:0]  longest;
  logic [LEN_W-1:0]  cur_run;
  logic              out_valid;
  logic [LEN_W-1:0]  out_len;

  logic              bm_qa;
  logic              bm_qb;
  logic [POS_W-1:0]  rs_q;
  logic [POS_W-1:0]  re_q;

  logic              left_r;
  logic              right_r;
  logic [POS_W-1:0]  rsl;
  logic [POS_W-1:0]  rer;

  logic              wa_rs_en;
  logic [POS_W-1:0]  wa_rs_addr;
  logic [POS_W-1:0]  wa_rs_data;
  logic              wa_re_en;
  logic [POS_W-1:0]  wa_re_addr;
  logic [POS_W-1:0]  wa_re_data;
  logic              wb_en;
  logic [POS_W-1:0]  wb_addr;
  logic [POS_W-1:0]  wb_data;

  logic [SZ_W-1:0]   n_used;
  logic [POS_W-1:0]  pm;
  logic [POS_W-1:0]  pm_dec;
  logic [POS_W:0]    pm_inc;
  logic [POS_W-1:0]  pos_dec;
  logic              in_range;
  logic              last;
  logic              right_c;
  logic              left_ld;
  logic [POS_W-1:0]  s_ld;
  logic [LEN_W-1:0]  cur_inc;
  logic [POS_W-1:0]  s_st;
  logic [POS_W-1:0]  e_st;
  logic [LEN_W-1:0]  len_st;
  logic              out_free;

  logic [AW-1:0]     bm_ra;
  logic [AW-1:0]     bm_rb;
  logic              bm_we;
  logic [AW-1:0]     bm_wa;
  logic              bm_wd;
  logic              rs_we;
  logic [POS_W-1:0]  rs_wa;
  logic [POS_W-1:0]  rs_wd;
  logic              re_we;
  logic [POS_W-1:0]  re_wa;
  logic [POS_W-1:0]  re_wd;

  assign n_used  = (SZ_W'(n_bits) < MAX_SZ) ? SZ_W'(n_bits) : MAX_SZ;
  assign pm      = cmd.take ? item.data.position : pos;
  assign pm_dec  = pm - POS_W'(1);
  assign pm_inc  = {1'b0, pm} + (POS_W + 1)'(1);
  assign pos_dec = pos - POS_W'(1);
  assign in_range = SZ_W'(item.data.position) < n_used;
  assign last    = (SZ_W'(pos) + SZ_W'(1)) == n_used;
  assign right_c = (SZ_W'(pos) + SZ_W'(1)) < n_used;
  assign left_ld = (pos != '0) && bm_qa;
  assign s_ld    = left_ld ? rs_q : pos;
  assign cur_inc = (cur_run == LEN_MAX) ? cur_run : cur_run + LEN_W'(1);
  assign s_st    = left_r ? rsl : pos;
  assign e_st    = right_r ? rer : pos;
  assign len_st  = (e_st >= s_st) ? ({1'b0, e_st} - {1'b0, s_st} + LEN_W'(1))
                                  : LEN_W'(1);
  assign out_free = !out_valid || result.ready;

  assign item.ready  = cmd.take;
  assign cfg.ready   = 1'b1;
  assign result.valid = out_valid;
  assign result.data.longest_run = out_len;

  always_comb begin
    stat            = '0;
    stat.item_valid = item.valid;
    stat.go_query   = item.data.mode == lort_pkg::MODE_QUERY;
    stat.go_load    = (item.data.mode == lort_pkg::MODE_LOAD) && in_range;
    stat.go_set     = (item.data.mode == lort_pkg::MODE_SET) && in_range;
    stat.bm_one     = bm_qa;
    stat.ld_more    = bitv ? last : left_ld;
    stat.need_b     = wb_en;
    stat.out_free   = out_free;
    stat.clr_last   = clr == CLR_END;
  end

  assign bm_ra = cmd.set_rd ? AW'(pos) : AW'(pm_dec);
  assign bm_rb = AW'(pm_inc);

  always_ff @(posedge clk) begin
    bm_qa <= bm_mem[bm_ra];
    bm_qb <= bm_mem[bm_rb];
    rs_q  <= rs_mem[AW'(pm_dec)];
    re_q  <= re_mem[AW'(pm_inc)];
  end

  always_comb begin
    bm_we = 1'b0;
    bm_wa = AW'(pos);
    bm_wd = 1'b0;
    rs_we = 1'b0;
    rs_wa = pos;
    rs_wd = '0;
    re_we = 1'b0;
    re_wa = pos;
    re_wd = '0;
    if (cmd.clear) begin
      bm_we = 1'b1;
      bm_wa = clr;
    end
    if (cmd.ld_exec) begin
      bm_we = 1'b1;
      bm_wd = bitv;
      rs_we = 1'b1;
      rs_wd = bitv ? s_ld : '0;
      re_we = 1'b1;
      re_wd = (bitv && last) ? pos : '0;
    end
    if (cmd.set_exec && !bm_qa) begin
      bm_we = 1'b1;
      bm_wd = 1'b1;
      rs_we = 1'b1;
      rs_wd = s_st;
      re_we = 1'b1;
      re_wd = e_st;
    end
    if (cmd.wr_a) begin
      rs_we = wa_rs_en && fits(wa_rs_addr);
      rs_wa = wa_rs_addr;
      rs_wd = wa_rs_data;
      re_we = wa_re_en && fits(wa_re_addr);
      re_wa = wa_re_addr;
      re_wd = wa_re_data;
    end
    if (cmd.wr_b) begin
      re_we = fits(wb_addr);
      re_wa = wb_addr;
      re_wd = wb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_wa] <= bm_wd;
    end
    if (rs_we) begin
      rs_mem[AW'(rs_wa)] <= rs_wd;
    end
    if (re_we) begin
      re_mem[AW'(re_wa)] <= re_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && item.valid) begin
      pos  <= item.data.position;
      bitv <= item.data.bit_value;
    end
    if (cmd.set_rd) begin
      left_r  <= (pos != '0) && bm_qa;
      right_r <= right_c && bm_qb;
      rsl     <= rs_q;
      rer     <= re_q;
    end
    if (cmd.ld_exec) begin
      wa_rs_en   <= 1'b0;
      wa_rs_addr <= pos;
      wa_rs_data <= pos;
      wa_re_en   <= bitv ? last : left_ld;
      wa_re_addr <= bitv ? s_ld : pos_dec;
      wa_re_data <= bitv ? pos : pos_dec;
      wb_en      <= !bitv && left_ld;
      wb_addr    <= rs_q;
      wb_data    <= pos_dec;
    end
    if (cmd.set_exec) begin
      wa_rs_en   <= 1'b1;
      wa_rs_addr <= e_st;
      wa_rs_data <= s_st;
      wa_re_en   <= 1'b1;
      wa_re_addr <= s_st;
      wa_re_data <= e_st;
      wb_en      <= 1'b0;
    end
    if (cmd.load_out) begin
      out_len <= longest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_bits    <= lort_pkg::N_BITS_RESET;
      clr       <= '0;
      longest   <= '0;
      cur_run   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        n_bits <= cfg.data.n_bits;
      end
      if (cmd.clear) begin
        clr <= clr + AW'(1);
      end
      if (cmd.ld_exec) begin
        if (bitv && !last) begin
          cur_run <= cur_inc;
        end else begin
          cur_run <= '0;
          longest <= len_max(longest, bitv ? cur_inc : cur_run);
        end
      end
      if (cmd.set_exec && !bm_qa) begin
        longest <= len_max(longest, len_st);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !item.ready)
    else $error("item taken during bitmap clear");

  a_longest_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> longest >= $past(longest))
    else $error("longest run decreased");

  a_wr_b_after_wr_a: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_b |-> $past(cmd.wr_a))
    else $error("third endpoint write out of sequence");

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.load_out))
    else $error("result beat without a query");

endmodule

// ===== rtl/longest_ones_run_tracker.sv =====
`timescale 1ns / 1ps

// Tracks the longest run of ones in a bitmap of up to MAX_BITS positions, with
// the start and end of each run kept at its two endpoints in a pair of
// single-write-port tables. After reset the bitmap is cleared one position per
// cycle, and during the clear no item is taken (configuration writes are taken).
// Then a query waits for any previous result beat to drain, and a load or a set
// takes its steps one after another; their number follows from the endpoint
// table write port, which a load that closes a run uses up to three times and
// a set twice, after the registered neighbour reads from the dual-read bitmap.
// Load, set and mode 3 items give no result beat; loads and sets at positions
// at or beyond the size in use are ignored; a query at any position gives one.

module longest_ones_run_tracker #(
  parameter int MAX_BITS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  lort_chan_if.sink   item,
  lort_chan_if.source result,
  lort_chan_if.sink   cfg
);

  lort_pkg::cmd_t  cmd;
  lort_pkg::stat_t stat;

  lort_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  lort_dpath #(
    .MAX_BITS (MAX_BITS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== test/longest_ones_run_tracker_tb.sv =====
`timescale 1ns / 1ps

module longest_ones_run_tracker_tb;

  localparam int MAX_POS = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lort_chan_if #(.T(lort_pkg::item_t))   item_if ();
  lort_chan_if #(.T(lort_pkg::result_t)) result_if ();
  lort_chan_if #(.T(lort_pkg::cfg_t))    cfg_if ();

  longest_ones_run_tracker #(
    .MAX_BITS(MAX_POS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item(item_if),
    .result(result_if),
    .cfg(cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the bitmap and endpoint tables
  logic                       map_bits  [MAX_POS];
  logic [lort_pkg::POS_W-1:0] start_of  [MAX_POS];
  logic [lort_pkg::POS_W-1:0] end_of    [MAX_POS];
  logic [lort_pkg::LEN_W-1:0] longest;
  logic [lort_pkg::LEN_W-1:0] open_run;
  logic [lort_pkg::CFG_W-1:0] size_cfg;

  logic [lort_pkg::LEN_W-1:0] expected_runs [$];

  int send_idle_pct;
  int recv_idle_pct;
  int active_items;
  int results_seen = 0;
  int size_writes;
  int mismatches = 0;
  int stall_cycles = 0;

  function automatic void fold_run(int len);
    if (len > 2047) len = 2047;
    if (len > int'(longest)) longest = lort_pkg::LEN_W'(len);
  endfunction

  function automatic void update_run_tables(lort_pkg::item_t it);
    int p, n, s, e, len;
    bit left, right;
    p = int'(it.position);
    n = (int'(size_cfg) < MAX_POS) ? int'(size_cfg) : MAX_POS;
    if (it.mode == lort_pkg::MODE_QUERY) begin
      expected_runs.push_back(longest);
      active_items++;
      return;
    end
    if ((it.mode != lort_pkg::MODE_LOAD && it.mode != lort_pkg::MODE_SET) ||
        p >= n) return;
    active_items++;
    left = (p > 0) && map_bits[p-1];
    if (it.mode == lort_pkg::MODE_LOAD) begin
      start_of[p] = '0;
      end_of[p] = '0;
      map_bits[p] = it.bit_value;
      if (it.bit_value) begin
        if (open_run < 2047) open_run++;
        start_of[p] = left ? start_of[p-1] : lort_pkg::POS_W'(p);
        if (p == n - 1) begin
          fold_run(int'(open_run));
          open_run = '0;
          end_of[p] = lort_pkg::POS_W'(p);
          end_of[start_of[p]] = lort_pkg::POS_W'(p);
        end
      end else begin
        fold_run(int'(open_run));
        open_run = '0;
        if (left) begin
          end_of[p-1] = lort_pkg::POS_W'(p - 1);
          end_of[start_of[p-1]] = lort_pkg::POS_W'(p - 1);
        end
      end
    end else begin
      if (map_bits[p]) return;
      right = (p + 1 < n) && map_bits[p+1];
      s = left ? int'(start_of[p-1]) : p;
      e = right ? int'(end_of[p+1]) : p;
      len = (e >= s) ? e - s + 1 : 1;
      start_of[p] = lort_pkg::POS_W'(s);
      end_of[p] = lort_pkg::POS_W'(e);
      start_of[e] = lort_pkg::POS_W'(s);
      end_of[s] = lort_pkg::POS_W'(e);
      fold_run(len);
      map_bits[p] = 1'b1;
    end
  endfunction

  task automatic send_item(logic [1:0] mode, int pos, logic bit_v);
    lort_pkg::item_t it;
    it.mode = mode;
    it.position = lort_pkg::POS_W'(pos);
    it.bit_value = bit_v;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data <= it;
    do @(posedge clk); while (!item_if.ready);
    update_run_tables(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_size(logic [lort_pkg::CFG_W-1:0] n);
    lort_pkg::cfg_t c;
    c.n_bits = n;
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= c;
    do @(posedge clk); while (!cfg_if.ready);
    size_cfg = n;
    size_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(lort_pkg::MODE_QUERY, 0, 1'b0);
    send_item(lort_pkg::MODE_LOAD, 0, 1'b1);
    send_item(lort_pkg::MODE_LOAD, 1, 1'b1);
    send_item(lort_pkg::MODE_LOAD, 2, 1'b0);
    send_item(lort_pkg::MODE_QUERY, 1023, 1'b1);
    send_item(lort_pkg::MODE_SET, 5, 1'b0);
    send_item(lort_pkg::MODE_SET, 4, 1'b0);
    send_item(lort_pkg::MODE_SET, 6, 1'b1);
    send_item(lort_pkg::MODE_SET, 2, 1'b0);
    send_item(lort_pkg::MODE_SET, 3, 1'b0);
    send_item(lort_pkg::MODE_SET, 3, 1'b1);
    send_item(lort_pkg::MODE_QUERY, 0, 1'b0);
    send_item(lort_pkg::MODE_LOAD, 1022, 1'b1);
    send_item(lort_pkg::MODE_LOAD, 1023, 1'b1);
    send_item(MODE_UNUSED, 1023, 1'b1);
    send_item(lort_pkg::MODE_LOAD, 1023, 1'b0);
    send_item(lort_pkg::MODE_QUERY, 0, 1'b0);
  endtask

  task automatic test_size_limits();
    wait_drained();
    write_size(11'd1);
    send_item(lort_pkg::MODE_LOAD, 0, 1'b0);
    send_item(lort_pkg::MODE_LOAD, 0, 1'b1);
    send_item(lort_pkg::MODE_SET, 1, 1'b0);
    send_item(lort_pkg::MODE_LOAD, 700, 1'b1);
    send_item(lort_pkg::MODE_QUERY, 0, 1'b0);
    wait_drained();
    write_size(11'd0);
    send_item(lort_pkg::MODE_LOAD, 0, 1'b1);
    send_item(lort_pkg::MODE_SET, 0, 1'b0);
    send_item(lort_pkg::MODE_QUERY, 0, 1'b0);
    wait_drained();
    write_size(11'd2047);
    send_item(lort_pkg::MODE_SET, 1023, 1'b0);
    send_item(lort_pkg::MODE_SET, 1020, 1'b0);
    send_item(lort_pkg::MODE_SET, 1021, 1'b0);
    send_item(lort_pkg::MODE_QUERY, 0, 1'b0);
  endtask

  // sized map, in-order load of random bits when it holds at most 64 positions, then sets and queries mixed with noise
  task automatic run_round();
    int n, eff, ones_pct, r, pos;
    if ($urandom_range(9) == 0) n = $urandom_range(2047);
    else n = $urandom_range(1, 40);
    eff = (n < MAX_POS) ? n : MAX_POS;
    ones_pct = $urandom_range(20, 90);
    wait_drained();
    write_size(lort_pkg::CFG_W'(n));
    if (eff <= 64) begin
      for (int p = 0; p < eff; p++) begin
        send_item(lort_pkg::MODE_LOAD, p, $urandom_range(99) < ones_pct);
        if ($urandom_range(99) < 12)
          send_item(lort_pkg::MODE_QUERY, $urandom_range(1023), 1'($urandom_range(1)));
      end
    end
    send_item(lort_pkg::MODE_QUERY, $urandom_range(1023), 1'($urandom_range(1)));
    repeat ($urandom_range(4, 20)) begin
      r = $urandom_range(99);
      pos = (eff > 0) ? $urandom_range(eff - 1) : 0;
      if (r < 55) send_item(lort_pkg::MODE_SET, pos, 1'($urandom_range(1)));
      else if (r < 75)
        send_item(lort_pkg::MODE_QUERY, $urandom_range(1023), 1'($urandom_range(1)));
      else if (r < 85)
        send_item($urandom_range(1) ? lort_pkg::MODE_SET : lort_pkg::MODE_LOAD,
                  $urandom_range(1023), 1'($urandom_range(1)));
      else if (r < 91) send_item(MODE_UNUSED, $urandom_range(1023), 1'($urandom_range(1)));
      else send_item(lort_pkg::MODE_LOAD, pos, 1'($urandom_range(1)));
    end
    send_item(lort_pkg::MODE_QUERY, $urandom_range(1023), 1'($urandom_range(1)));
  endtask

  task automatic test_random(int send_pct, int recv_pct, int target);
    int first;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = active_items;
    while (active_items - first < target) run_round();
  endtask

  task automatic test_long_run();
    wait_drained();
    write_size(11'd1024);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (150) send_item(lort_pkg::MODE_LOAD, 1, 1'b1);
    send_item(lort_pkg::MODE_LOAD, 1, 1'b0);
    send_item(lort_pkg::MODE_QUERY, 0, 1'b0);
  endtask

  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      results_seen++;
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: longest_run %0d", result_if.data.longest_run);
      end else begin
        if (result_if.data.longest_run !== expected_runs[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("longest_run mismatch: expected %0d, got %0d",
                     expected_runs[0], result_if.data.longest_run);
        end
        void'(expected_runs.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    item_if.valid = 1'b0;
    item_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int i = 0; i < MAX_POS; i++) begin
      map_bits[i] = 1'b0;
      start_of[i] = '0;
      end_of[i] = '0;
    end
    longest = '0;
    open_run = '0;
    size_cfg = lort_pkg::N_BITS_RESET;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    active_items = 0;
    size_writes = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_size_limits();
    test_random(8, 57, 240);
    test_random(57, 8, 240);
    test_random(0, 0, 240);
    test_long_run();

    wait_drained();
    repeat (32) @(negedge clk);
    $display("Ran %0d load/set/query items over %0d map size writes, checked %0d results,",
             active_items, size_writes, results_seen);
    $display("including merges, map-edge sizes and a long run of ones at one position.");
    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_runs.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lort_pkg.sv
rtl/lort_chan_if.sv
rtl/lort_ctrl.sv
rtl/lort_dpath.sv
rtl/longest_ones_run_tracker.sv
test/longest_ones_run_tracker_tb.sv
